[sv/vpu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpu_pkg
// Shared constants and types for the vertex project / unproject pipeline.
// ----------------------------------------------------------------------------
package vpu_pkg;

	localparam int FRAC_BITS = 16;
	localparam int NUM_REGS  = 8;
	localparam int IDX_W     = 3;
	// width of a matrix row sum: three 64-bit products plus a column term
	localparam int SUM_W     = 68;
	// quotient bits kept by the divide pipeline
	localparam int DIV_STEPS = 32 + FRAC_BITS + 1;

	typedef enum logic [1:0] {
		REQ_PERSP_PROJ   = 2'd0,
		REQ_ORTHO_PROJ   = 2'd1,
		REQ_PERSP_UNPROJ = 2'd2,
		REQ_ORTHO_UNPROJ = 2'd3
	} req_t;

	typedef struct packed {
		logic persp;
		logic unproj;
	} mode_t;

	function automatic logic signed [31:0] sat32(input logic signed [SUM_W+1:0] v);
		logic signed [SUM_W+1:0] hi;
		logic signed [SUM_W+1:0] lo;
		hi = (SUM_W+2)'(signed'(32'sh7fffffff));
		lo = (SUM_W+2)'(signed'(32'sh80000000));
		if (v > hi) return 32'sh7fffffff;
		if (v < lo) return 32'sh80000000;
		return v[31:0];
	endfunction

endpackage

[sv/vpu_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpu_if
// Valid/ready channels for points, results and configuration writes.
// ----------------------------------------------------------------------------
interface vpu_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic signed [31:0] in_x;
	logic signed [31:0] in_y;
	logic signed [31:0] in_z;
	logic [15:0] screen_width;
	logic [15:0] screen_height;
	modport source (output valid, req_type, in_x, in_y, in_z, screen_width, screen_height,
		input ready);
	modport sink (input valid, req_type, in_x, in_y, in_z, screen_width, screen_height,
		output ready);
endinterface

interface vpu_out_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	modport source (output valid, ok, out_x, out_y, out_z, input ready);
	modport sink (input valid, ok, out_x, out_y, out_z, output ready);
endinterface

interface vpu_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[sv/vpu_divstep.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpu_divstep
// One restoring divide step: shift in a numerator bit, compare, subtract.
// ----------------------------------------------------------------------------
module vpu_divstep (
	input  logic [vpu_pkg::SUM_W-1:0] rem,
	input  logic                      nbit,
	input  logic [vpu_pkg::SUM_W-1:0] den,
	output logic [vpu_pkg::SUM_W-1:0] rem_nx,
	output logic                      qbit
);
	logic [vpu_pkg::SUM_W:0] trial;
	always_comb begin
		trial  = {rem, nbit};
		qbit   = trial >= {1'b0, den};
		rem_nx = qbit ? vpu_pkg::SUM_W'(trial - {1'b0, den})
			: vpu_pkg::SUM_W'(trial);
	end
endmodule

[sv/vertex_project_unproject_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_project_unproject_unit
// Perspective / ortho project and unproject of one point per unstalled cycle.
// ----------------------------------------------------------------------------
// Usage: points enter on pt (valid/ready), results leave on res, matrix rows
// are written on cfg (index 0..7, two Q16.16 columns per 64-bit word).
// Pipeline, one word accepted per cycle while res does not stall:
//   34 restoring divide stages for the screen-to-clip step (2s/res),
//   s1 clip value select, s2 matrix products, s3 row sums and w test,
//   then 49 divide steps (one per stage) for the perspective quotient,
//   s4 select and saturate, s5 clip-to-screen multiply, output register.
// Throughput is one word per cycle, back to back, while res does not stall.
// Reset clears all valid bits and loads the identity matrix.
// When res stalls, the whole pipeline holds (ready falls); nothing is lost.
// The user must write configuration only while the pipeline is empty; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module vertex_project_unproject_unit (
	input  logic clk,
	input  logic arst_n,
	vpu_in_if.sink    pt,
	vpu_out_if.source res,
	vpu_cfg_if.sink   cfg
);
	localparam int SW = vpu_pkg::SUM_W;
	localparam int FB = vpu_pkg::FRAC_BITS;
	localparam int PD = 34;      // pre-divide stages (screen to clip)
	localparam int MD = vpu_pkg::DIV_STEPS;

	logic [63:0] regs_q [vpu_pkg::NUM_REGS];
	logic adv;
	assign adv = !res.valid || res.ready;
	assign pt.ready = adv;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[0] <= 64'd65536; regs_q[1] <= 64'd0;
			regs_q[2] <= 64'd65536 << 32; regs_q[3] <= 64'd0;
			regs_q[4] <= 64'd0; regs_q[5] <= 64'd65536;
			regs_q[6] <= 64'd0; regs_q[7] <= 64'd65536 << 32;
		end else if (cfg.valid) begin
			regs_q[cfg.index] <= cfg.data;
		end
	end

	// ---------------- screen to clip: (2s)/res truncated, 34 steps -------------
	typedef struct packed {
		vpu_pkg::mode_t mode;
		logic [15:0] rw, rh;
		logic signed [31:0] x, y, z;
		logic nx, ny;
		logic [33:0] mx, my;    // numerator shifting out
		logic [33:0] qx, qy;
		logic [SW-1:0] rx, ry;
	} pre_t;

	pre_t pre_s [PD+1];
	logic pv_s [PD+1];

	always_comb begin
		pre_s[0].mode.persp  = !pt.req_type[0];
		pre_s[0].mode.unproj = pt.req_type[1];
		pre_s[0].rw = (pt.screen_width == 16'd0) ? 16'd1 : pt.screen_width;
		pre_s[0].rh = (pt.screen_height == 16'd0) ? 16'd1 : pt.screen_height;
		pre_s[0].x = pt.in_x; pre_s[0].y = pt.in_y; pre_s[0].z = pt.in_z;
		pre_s[0].nx = pt.in_x[31]; pre_s[0].ny = pt.in_y[31];
		pre_s[0].mx = pt.in_x[31] ? 34'(-{{2{pt.in_x[31]}}, pt.in_x}) << 1
			: 34'({2'b0, pt.in_x}) << 1;
		pre_s[0].my = pt.in_y[31] ? 34'(-{{2{pt.in_y[31]}}, pt.in_y}) << 1
			: 34'({2'b0, pt.in_y}) << 1;
		pre_s[0].qx = '0; pre_s[0].qy = '0;
		pre_s[0].rx = '0; pre_s[0].ry = '0;
		pv_s[0] = pt.valid;
	end

	for (genvar i = 0; i < PD; i++) begin : g_pre
		pre_t nx_st;
		logic bx, by;
		logic [SW-1:0] rxn, ryn;
		vpu_divstep u_dx (.rem(pre_s[i].rx), .nbit(pre_s[i].mx[33]),
			.den(SW'(pre_s[i].rw)), .rem_nx(rxn), .qbit(bx));
		vpu_divstep u_dy (.rem(pre_s[i].ry), .nbit(pre_s[i].my[33]),
			.den(SW'(pre_s[i].rh)), .rem_nx(ryn), .qbit(by));
		always_comb begin
			nx_st = pre_s[i];
			nx_st.mx = pre_s[i].mx << 1; nx_st.my = pre_s[i].my << 1;
			nx_st.qx = {pre_s[i].qx[32:0], bx}; nx_st.qy = {pre_s[i].qy[32:0], by};
			nx_st.rx = rxn; nx_st.ry = ryn;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) pv_s[i+1] <= 1'b0;
			else if (adv) pv_s[i+1] <= pv_s[i];
		end
		always_ff @(posedge clk) if (adv) pre_s[i+1] <= nx_st;
	end

	// ---------------- s1: clip value select -------------------------------------
	vpu_pkg::mode_t mode_s1;
	logic [15:0] rw_s1, rh_s1;
	logic signed [31:0] v0_s1, v1_s1, v2_s1;
	logic v_s1;
	logic signed [SW+1:0] cx, cy;
	pre_t pe;
	assign pe = pre_s[PD];
	always_comb begin
		cx = (pe.nx ? -(SW+2)'(signed'({1'b0, pe.qx})) : (SW+2)'(signed'({1'b0, pe.qx})))
			- (SW+2)'(signed'(1 << FB));
		cy = (pe.ny ? -(SW+2)'(signed'({1'b0, pe.qy})) : (SW+2)'(signed'({1'b0, pe.qy})))
			- (SW+2)'(signed'(1 << FB));
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= pv_s[PD];
	end
	always_ff @(posedge clk) if (adv) begin
		mode_s1 <= pe.mode; rw_s1 <= pe.rw; rh_s1 <= pe.rh;
		v0_s1 <= pe.mode.unproj ? vpu_pkg::sat32(cx) : pe.x;
		v1_s1 <= pe.mode.unproj ? vpu_pkg::sat32(cy) : pe.y;
		v2_s1 <= pe.z;
	end

	// ---------------- s2: twelve 32x32 products ----------------------------------
	logic signed [63:0] p_s2 [4][3];
	logic signed [31:0] c3_s2 [4];
	vpu_pkg::mode_t mode_s2;
	logic [15:0] rw_s2, rh_s2;
	logic v_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) if (adv) begin
		mode_s2 <= mode_s1; rw_s2 <= rw_s1; rh_s2 <= rh_s1;
		for (int r = 0; r < 4; r++) begin
			p_s2[r][0] <= signed'(regs_q[2*r][31:0]) * v0_s1;
			p_s2[r][1] <= signed'(regs_q[2*r][63:32]) * v1_s1;
			p_s2[r][2] <= signed'(regs_q[2*r+1][31:0]) * v2_s1;
			c3_s2[r]   <= signed'(regs_q[2*r+1][63:32]);
		end
	end

	// ---------------- s3: row sums floored, w test -------------------------------
	// sum of products then arithmetic shift equals the floored sum of pieces
	logic signed [SW-1:0] t_s3 [4];
	vpu_pkg::mode_t mode_s3;
	logic [15:0] rw_s3, rh_s3;
	logic v_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) if (adv) begin
		mode_s3 <= mode_s2; rw_s3 <= rw_s2; rh_s3 <= rh_s2;
		for (int r = 0; r < 4; r++)
			t_s3[r] <= SW'((SW'(p_s2[r][0]) + SW'(p_s2[r][1]) + SW'(p_s2[r][2])) >>> FB)
				+ SW'(c3_s2[r]);
	end

	// ---------------- divide pipeline: (|t| << FB) / w ---------------------------
	localparam int NW = SW + FB;
	typedef struct packed {
		vpu_pkg::mode_t mode;
		logic ok;
		logic [15:0] rw, rh;
		logic [2:0] neg;
		logic [SW-1:0] den;
		logic signed [SW-1:0] t0, t1, t2;
		logic [NW-1:0] n0, n1, n2;
		logic [MD-1:0] q0, q1, q2;
		logic [SW-1:0] r0, r1, r2;
	} dv_t;

	dv_t dv_s [MD+1];
	logic dvv_s [MD+1];
	logic [SW-1:0] a0, a1, a2;
	always_comb begin
		a0 = t_s3[0][SW-1] ? SW'(-t_s3[0]) : SW'(t_s3[0]);
		a1 = t_s3[1][SW-1] ? SW'(-t_s3[1]) : SW'(t_s3[1]);
		a2 = t_s3[2][SW-1] ? SW'(-t_s3[2]) : SW'(t_s3[2]);
		dv_s[0].mode = mode_s3;
		dv_s[0].ok = !t_s3[3][SW-1] && (t_s3[3] != '0);
		dv_s[0].rw = rw_s3; dv_s[0].rh = rh_s3;
		dv_s[0].neg = {t_s3[2][SW-1], t_s3[1][SW-1], t_s3[0][SW-1]};
		dv_s[0].den = t_s3[3];
		dv_s[0].t0 = t_s3[0]; dv_s[0].t1 = t_s3[1]; dv_s[0].t2 = t_s3[2];
		// only the low MD bits of the quotient matter after saturation check
		dv_s[0].n0 = NW'(a0) << FB; dv_s[0].n1 = NW'(a1) << FB;
		dv_s[0].n2 = NW'(a2) << FB;
		dv_s[0].q0 = '0; dv_s[0].q1 = '0; dv_s[0].q2 = '0;
		dv_s[0].r0 = '0; dv_s[0].r1 = '0; dv_s[0].r2 = '0;
		dvv_s[0] = v_s3;
	end

	// high numerator bits beyond MD steps are folded in during step 0
	for (genvar i = 0; i < MD; i++) begin : g_div
		dv_t st;
		logic b0, b1, b2;
		logic [SW-1:0] q0n, q1n, q2n, ri0, ri1, ri2;
		logic [SW-1:0] hi0, hi1, hi2;
		always_comb begin
			hi0 = SW'(dv_s[i].n0 >> MD); hi1 = SW'(dv_s[i].n1 >> MD);
			hi2 = SW'(dv_s[i].n2 >> MD);
			ri0 = (i == 0) ? hi0 : dv_s[i].r0;
			ri1 = (i == 0) ? hi1 : dv_s[i].r1;
			ri2 = (i == 0) ? hi2 : dv_s[i].r2;
		end
		vpu_divstep u0 (.rem(ri0), .nbit(dv_s[i].n0[MD-1-i]), .den(dv_s[i].den),
			.rem_nx(q0n), .qbit(b0));
		vpu_divstep u1 (.rem(ri1), .nbit(dv_s[i].n1[MD-1-i]), .den(dv_s[i].den),
			.rem_nx(q1n), .qbit(b1));
		vpu_divstep u2 (.rem(ri2), .nbit(dv_s[i].n2[MD-1-i]), .den(dv_s[i].den),
			.rem_nx(q2n), .qbit(b2));
		always_comb begin
			st = dv_s[i];
			st.r0 = q0n; st.r1 = q1n; st.r2 = q2n;
			// a remainder at or above den at step 0 means quotient overflow
			st.q0 = {dv_s[i].q0[MD-2:0], b0} | ((i == 0 && ri0 >= dv_s[i].den) ? '1 : '0);
			st.q1 = {dv_s[i].q1[MD-2:0], b1} | ((i == 0 && ri1 >= dv_s[i].den) ? '1 : '0);
			st.q2 = {dv_s[i].q2[MD-2:0], b2} | ((i == 0 && ri2 >= dv_s[i].den) ? '1 : '0);
			if (i != 0) begin
				st.q0 = {dv_s[i].q0[MD-2:0], b0} | (&dv_s[i].q0 ? '1 : '0);
				st.q1 = {dv_s[i].q1[MD-2:0], b1} | (&dv_s[i].q1 ? '1 : '0);
				st.q2 = {dv_s[i].q2[MD-2:0], b2} | (&dv_s[i].q2 ? '1 : '0);
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dvv_s[i+1] <= 1'b0;
			else if (adv) dvv_s[i+1] <= dvv_s[i];
		end
		always_ff @(posedge clk) if (adv) dv_s[i+1] <= st;
	end

	// ---------------- s4: select / saturate --------------------------------------
	dv_t de;
	assign de = dv_s[MD];
	logic signed [31:0] c_s4 [3];
	vpu_pkg::mode_t mode_s4;
	logic ok_s4, v_s4;
	logic [15:0] rw_s4, rh_s4;
	function automatic logic signed [31:0] qsel(input logic [MD-1:0] q, input logic n);
		logic signed [SW+1:0] m;
		m = (SW+2)'(signed'({1'b0, q}));
		return vpu_pkg::sat32(n ? -m : m);
	endfunction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= dvv_s[MD];
	end
	always_ff @(posedge clk) if (adv) begin
		mode_s4 <= de.mode; ok_s4 <= de.ok; rw_s4 <= de.rw; rh_s4 <= de.rh;
		c_s4[0] <= de.mode.persp ? qsel(de.q0, de.neg[0]) : vpu_pkg::sat32((SW+2)'(de.t0));
		c_s4[1] <= de.mode.persp ? qsel(de.q1, de.neg[1]) : vpu_pkg::sat32((SW+2)'(de.t1));
		c_s4[2] <= de.mode.persp ? qsel(de.q2, de.neg[2]) : vpu_pkg::sat32((SW+2)'(de.t2));
	end

	// ---------------- s5: clip to screen multiply --------------------------------
	logic signed [50:0] sx_s5, sy_s5;
	logic signed [31:0] z_s5, cx_s5, cy_s5;
	vpu_pkg::mode_t mode_s5;
	logic ok_s5, v_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) if (adv) begin
		mode_s5 <= mode_s4; ok_s5 <= ok_s4;
		sx_s5 <= (51'(c_s4[0]) + 51'(1 << FB)) * signed'({35'd0, rw_s4});
		sy_s5 <= (51'(c_s4[1]) + 51'(1 << FB)) * signed'({35'd0, rh_s4});
		cx_s5 <= c_s4[0]; cy_s5 <= c_s4[1]; z_s5 <= c_s4[2];
	end

	// ---------------- output register --------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res.valid <= 1'b0;
		else if (adv) res.valid <= v_s5;
	end
	always_ff @(posedge clk) if (adv) begin
		res.ok <= ok_s5;
		if (!ok_s5) begin
			res.out_x <= '0; res.out_y <= '0; res.out_z <= '0;
		end else begin
			res.out_x <= mode_s5.unproj ? cx_s5 : vpu_pkg::sat32((SW+2)'(sx_s5 >>> 1));
			res.out_y <= mode_s5.unproj ? cy_s5 : vpu_pkg::sat32((SW+2)'(sy_s5 >>> 1));
			res.out_z <= z_s5;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.out_x))
		else $error("result changed under stall");
	a_rej: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ok |-> res.out_x == 0 && res.out_y == 0 && res.out_z == 0)
		else $error("rejected point not zeroed");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |-> !pt.ready)
		else $error("input taken while output stalled");
endmodule

[verif/tb_vertex_project_unproject_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vertex_project_unproject_unit
// Self-checking bench for the project / unproject pipeline: a directed table,
// then random points under several matrices, with bursty input, a stalling
// output side and a long output hold-off, checked against table values or a predictor.
// ----------------------------------------------------------------------------
module tb_vertex_project_unproject_unit;

	localparam int N_RANDOM  = 1250;
	localparam int LATENCY   = 89;
	localparam int CYC_LIMIT = 400000;

	typedef struct {
		vpu_pkg::req_t req;
		logic signed [31:0] x, y, z;
		logic [15:0] w, h;
	} point_t;

	typedef struct {
		logic ok;
		logic signed [31:0] x, y, z;
	} proj_t;

	typedef struct {
		point_t pt;
		logic   known;
		proj_t  res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	vpu_in_if  pt_if ();
	vpu_out_if res_if ();
	vpu_cfg_if cfg_if ();

	vertex_project_unproject_unit DUT (
		.clk(clk), .arst_n(arst_n), .pt(pt_if.sink), .res(res_if.source), .cfg(cfg_if.sink)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [63:0] mat_regs [vpu_pkg::NUM_REGS];
	proj_t expected_q[$];
	int errors = 0;
	int results_seen = 0;
	int rejects_seen = 0;
	longint cycles = 0;
	bit hold_off = 1'b0;
	int hold_cnt = 0;

	// ---------------- predictor ----------------
	function automatic longint sx(logic [31:0] v);
		return longint'(signed'(v));
	endfunction

	function automatic longint sat(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint mcoef(int r, int c);
		logic [63:0] wd;
		wd = mat_regs[r*2 + c/2];
		return sx((c % 2) ? wd[63:32] : wd[31:0]);
	endfunction

	// row times (v,1), exact sum floored to the fraction width
	function automatic logic signed [95:0] row_sum(int r, longint v0, longint v1, longint v2);
		logic signed [95:0] acc;
		acc = 96'(mcoef(r, 0)) * 96'(v0) + 96'(mcoef(r, 1)) * 96'(v1)
			+ 96'(mcoef(r, 2)) * 96'(v2);
		return (acc >>> vpu_pkg::FRAC_BITS) + 96'(mcoef(r, 3));
	endfunction

	function automatic longint qdiv(logic signed [95:0] num, logic signed [95:0] den);
		logic signed [127:0] n, q;
		n = 128'(num) <<< vpu_pkg::FRAC_BITS;
		q = n / 128'(den);
		if (q > 128'sd2147483647) return 64'sd2147483647;
		if (q < -128'sd2147483648) return -64'sd2147483648;
		return longint'(q);
	endfunction

	function automatic proj_t project_point(point_t p);
		proj_t o;
		longint rw, rh, v0, v1, v2;
		logic signed [95:0] t [3];
		logic signed [95:0] wv;
		longint c [3];
		bit unproj, persp;
		unproj = (p.req == vpu_pkg::REQ_PERSP_UNPROJ) || (p.req == vpu_pkg::REQ_ORTHO_UNPROJ);
		persp = (p.req == vpu_pkg::REQ_PERSP_PROJ) || (p.req == vpu_pkg::REQ_PERSP_UNPROJ);
		rw = (p.w == 0) ? 1 : p.w;
		rh = (p.h == 0) ? 1 : p.h;
		v0 = sx(p.x);
		v1 = sx(p.y);
		v2 = sx(p.z);
		if (unproj) begin
			v0 = sat((2 * v0) / rw - (64'sd1 << vpu_pkg::FRAC_BITS));
			v1 = sat((2 * v1) / rh - (64'sd1 << vpu_pkg::FRAC_BITS));
		end
		for (int i = 0; i < 3; i++) t[i] = row_sum(i, v0, v1, v2);
		wv = row_sum(3, v0, v1, v2);
		o.ok = 1'b0;
		o.x = '0;
		o.y = '0;
		o.z = '0;
		if (wv <= 0) return o;
		for (int i = 0; i < 3; i++)
			c[i] = persp ? qdiv(t[i], wv)
				: (t[i] > 96'sd2147483647 ? 64'sd2147483647
				: (t[i] < -96'sd2147483648 ? -64'sd2147483648 : longint'(t[i])));
		if (!unproj) begin
			c[0] = sat((c[0] + (64'sd1 << vpu_pkg::FRAC_BITS)) * rw >>> 1);
			c[1] = sat((c[1] + (64'sd1 << vpu_pkg::FRAC_BITS)) * rh >>> 1);
		end
		o.ok = 1'b1;
		o.x = c[0][31:0];
		o.y = c[1][31:0];
		o.z = c[2][31:0];
		return o;
	endfunction

	// ---------------- drivers ----------------
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom();
			3: return $urandom_range(0, 32'h0200_0000);
			default: return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
		endcase
	endfunction

	function automatic point_t rand_point();
		point_t p;
		p.req = vpu_pkg::req_t'($urandom_range(0, 3));
		p.x = rand_coord();
		p.y = rand_coord();
		p.z = rand_coord();
		p.w = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(1, 2048));
		p.h = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(1, 2048));
		return p;
	endfunction

	task automatic send_point(point_t p, logic known, proj_t want);
		proj_t pred;
		pred = project_point(p);
		if (known && pred != want)
			$display("table row disagrees with predictor: req %0d", p.req);
		pt_if.valid <= 1'b1;
		pt_if.req_type <= p.req;
		pt_if.in_x <= p.x;
		pt_if.in_y <= p.y;
		pt_if.in_z <= p.z;
		pt_if.screen_width <= p.w;
		pt_if.screen_height <= p.h;
		do @(posedge clk); while (!pt_if.ready);
		expected_q.push_back(known ? want : pred);
		@(negedge clk);
	endtask

	task automatic idle_gap(int n);
		if (n > 0) begin
			pt_if.valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic drain();
		pt_if.valid <= 1'b0;
		wait (expected_q.size() == 0);
		repeat (LATENCY + 10) @(negedge clk);
	endtask

	// leaves valid high so back-to-back writes need no gap
	task automatic write_reg(int idx, logic [63:0] d);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx[vpu_pkg::IDX_W-1:0];
		cfg_if.data <= d;
		do @(posedge clk); while (!cfg_if.ready);
		mat_regs[idx] = d;
		@(negedge clk);
	endtask

	function automatic logic [63:0] pair(logic [31:0] lo, logic [31:0] hi);
		return {hi, lo};
	endfunction

	function automatic logic [31:0] noise(bit big);
		return big ? 32'($urandom_range(0, 32'h0004_0000)) : 32'($urandom_range(0, 32'h800));
	endfunction

	task automatic load_matrix(int kind);
		logic [31:0] one;
		one = 32'h0001_0000;
		for (int r = 0; r < 4; r++) begin
			for (int k = 0; k < 2; k++) begin
				logic [63:0] d;
				case (kind)
					0: d = pair((r == 2*k) ? one : 0, (r == 2*k+1) ? one : 0);
					// perspective-like: w = -z plus a small constant, other rows random noise
					1: d = (r == 3) ? (k == 1 ? pair(32'hffff_0000, 32'h0000_1000) : 64'h0)
						: pair(noise(r == 2*k), noise(r == 2*k+1));
					2: d = {$urandom(), $urandom()};
					3: d = (r == 3) ? {32'h7fff_ffff, 32'h7fff_ffff} : {32'h8000_0000, 32'h7fff_ffff};
					default: d = (r == 3 && k == 1) ? pair(32'h0000_0000, 32'h0001_0000)
						: pair(32'($urandom_range(0, 32'h0002_0000)), 32'($urandom_range(0, 32'h400)));
				endcase
				write_reg(r*2 + k, d);
			end
		end
		cfg_if.valid <= 1'b0;
	endtask

	task automatic load_matrix_reset();
		mat_regs[0] = 64'd65536;
		mat_regs[1] = 64'd0;
		mat_regs[2] = 64'd65536 << 32;
		mat_regs[3] = 64'd0;
		mat_regs[4] = 64'd0;
		mat_regs[5] = 64'd65536;
		mat_regs[6] = 64'd0;
		mat_regs[7] = 64'd65536 << 32;
	endtask

	// ---------------- directed table ----------------
	row_t dir_rows[$];

	task automatic add_row(vpu_pkg::req_t r, logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [15:0] w, logic [15:0] h, logic known, logic ok,
			logic [31:0] ex, logic [31:0] ey, logic [31:0] ez);
		row_t e;
		e.pt.req = r; e.pt.x = x; e.pt.y = y; e.pt.z = z; e.pt.w = w; e.pt.h = h;
		e.known = known;
		e.res.ok = ok; e.res.x = ex; e.res.y = ey; e.res.z = ez;
		dir_rows.push_back(e);
	endtask

	task automatic build_table();
		// identity: clip origin lands in the screen center
		add_row(vpu_pkg::REQ_PERSP_PROJ, 0, 0, 0, 100, 50, 1, 1,
			32'h0032_0000, 32'h0019_0000, 0);
		add_row(vpu_pkg::REQ_ORTHO_PROJ, 0, 0, 32'h0001_0000, 100, 50, 1, 1,
			32'h0032_0000, 32'h0019_0000, 32'h0001_0000);
		// zero resolution behaves as one pixel
		add_row(vpu_pkg::REQ_ORTHO_PROJ, 0, 0, 0, 0, 0, 1, 1, 32'h0000_8000, 32'h0000_8000, 0);
		add_row(vpu_pkg::REQ_PERSP_UNPROJ, 0, 0, 0, 0, 0, 1, 1, 32'hffff_0000, 32'hffff_0000, 0);
		add_row(vpu_pkg::REQ_ORTHO_UNPROJ, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			16'hffff, 16'hffff, 0, 0, 0, 0, 0);
		add_row(vpu_pkg::REQ_PERSP_PROJ, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
			16'hffff, 1, 0, 0, 0, 0, 0);
		add_row(vpu_pkg::REQ_ORTHO_PROJ, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
			1, 16'hffff, 0, 0, 0, 0, 0);
		add_row(vpu_pkg::REQ_PERSP_UNPROJ, 32'h8000_0000, 32'h7fff_ffff, 0, 1, 1,
			0, 0, 0, 0, 0);
		add_row(vpu_pkg::REQ_ORTHO_UNPROJ, 32'h0064_0000, 32'h0032_0000, 32'h5555_aaaa,
			200, 100, 0, 0, 0, 0, 0);
	endtask

	// ---------------- receiver ----------------
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			res_if.ready <= 1'b0;
			hold_cnt <= hold_cnt - 1;
		end else if (hold_off) begin
			res_if.ready <= 1'b0;
			hold_cnt <= 300;
		end else begin
			res_if.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && res_if.valid && res_if.ready) begin
			proj_t got, exp_r;
			got.ok = res_if.ok;
			got.x = res_if.out_x;
			got.y = res_if.out_y;
			got.z = res_if.out_z;
			results_seen++;
			if (!got.ok) rejects_seen++;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected word: ok %b x %h", got.ok, got.x);
			end else begin
				exp_r = expected_q.pop_front();
				if (got != exp_r) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp ok %b %h %h %h got ok %b %h %h %h",
							exp_r.ok, exp_r.x, exp_r.y, exp_r.z,
							got.ok, got.x, got.y, got.z);
				end
			end
		end
		if (cycles > CYC_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("vertex_project_unproject_unit regression: fail");
			$finish;
		end
	end

	// ---------------- main sequence ----------------
	initial begin
		int burst;
		pt_if.valid = 1'b0;
		pt_if.req_type = vpu_pkg::REQ_PERSP_PROJ;
		pt_if.in_x = '0;
		pt_if.in_y = '0;
		pt_if.in_z = '0;
		pt_if.screen_width = 16'd1;
		pt_if.screen_height = 16'd1;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		res_if.ready = 1'b0;
		load_matrix_reset();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		build_table();
		foreach (dir_rows[i]) send_point(dir_rows[i].pt, dir_rows[i].known, dir_rows[i].res);
		drain();

		// long output hold-off while points keep coming
		hold_off = 1'b1;
		wait (hold_cnt > 0);
		hold_off = 1'b0;
		for (int i = 0; i < 150; i++) send_point(rand_point(), 1'b0, '{default: '0});
		drain();

		for (int phase = 0; phase < 7; phase++) begin
			load_matrix(phase % 5);
			burst = 0;
			for (int i = 0; i < N_RANDOM / 7; i++) begin
				if (burst == 0) begin
					idle_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 8));
					burst = $urandom_range(1, 40);
				end
				burst--;
				send_point(rand_point(), 1'b0, '{default: '0});
			end
			drain();
		end

		$display("covered %0d results (%0d rejected) over identity, perspective, random",
			results_seen, rejects_seen);
		$display("and extreme matrices, %0d cycles", cycles);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("vertex_project_unproject_unit regression: pass");
		end else begin
			$display("vertex_project_unproject_unit regression: fail");
		end
		$finish;
	end

endmodule

[filelist.f]
sv/vpu_pkg.sv
sv/vpu_if.sv
sv/vpu_divstep.sv
sv/vertex_project_unproject_unit.sv
verif/tb_vertex_project_unproject_unit.sv
